// ===== rtl/core/rvx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared constants, codes and types of the RV32IM instruction executor.
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam int unsigned MEM_BYTES_DEFAULT = 65536;

   // major opcodes
   localparam logic [6:0] OPC_OP     = 7'd51;
   localparam logic [6:0] OPC_LOAD   = 7'd3;
   localparam logic [6:0] OPC_OPIMM  = 7'd19;
   localparam logic [6:0] OPC_JALR   = 7'd103;
   localparam logic [6:0] OPC_SYSTEM = 7'd115;
   localparam logic [6:0] OPC_STORE  = 7'd35;
   localparam logic [6:0] OPC_BRANCH = 7'd99;
   localparam logic [6:0] OPC_AUIPC  = 7'd23;
   localparam logic [6:0] OPC_LUI    = 7'd55;
   localparam logic [6:0] OPC_JAL    = 7'd111;

   // funct7 values
   localparam logic [6:0] F7_BASE   = 7'd0;
   localparam logic [6:0] F7_ALT    = 7'd32;
   localparam logic [6:0] F7_MULDIV = 7'd1;

   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

   // environment call register numbers and service codes
   localparam logic [4:0]  A0_INDEX      = 5'd10;
   localparam logic [4:0]  A1_INDEX      = 5'd11;
   localparam logic [31:0] EC_PRINT_INT  = 32'd1;
   localparam logic [31:0] EC_PRINT_STR  = 32'd4;
   localparam logic [31:0] EC_EXIT       = 32'd10;
   localparam logic [31:0] EC_PRINT_CHAR = 32'd11;

   // instruction classes handed from front to back
   typedef logic [3:0] class_type;
   localparam class_type CL_ALU_R   = 4'd0;
   localparam class_type CL_ALU_I   = 4'd1;
   localparam class_type CL_MUL     = 4'd2;
   localparam class_type CL_DIV     = 4'd3;
   localparam class_type CL_LOAD    = 4'd4;
   localparam class_type CL_STORE   = 4'd5;
   localparam class_type CL_BRANCH  = 4'd6;
   localparam class_type CL_JAL     = 4'd7;
   localparam class_type CL_JALR    = 4'd8;
   localparam class_type CL_AUIPC   = 4'd9;
   localparam class_type CL_LUI     = 4'd10;
   localparam class_type CL_ECALL   = 4'd11;
   localparam class_type CL_ILLEGAL = 4'd12;

   // result status
   typedef logic [2:0] status_type;
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_ILLEGAL     = 3'd1;
   localparam status_type ST_LOAD_FAULT  = 3'd2;
   localparam status_type ST_STORE_FAULT = 3'd3;
   localparam status_type ST_ECALL       = 3'd4;
   localparam status_type ST_EXIT        = 3'd5;
   localparam status_type ST_HALTED      = 3'd6;

   typedef struct packed {
      logic [31:0] instruction;
      class_type   op_class;
   } item_type;

endpackage

// ===== rtl/core/rvx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rvx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;
   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface rvx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        reg_write_enable;
   logic [4:0]  reg_write_index;
   logic [31:0] reg_write_value;
   logic [2:0]  status;
   logic [31:0] ecall_code;
   logic [31:0] ecall_arg;
   modport source (output valid, output next_pc, output reg_write_enable,
                   output reg_write_index, output reg_write_value, output status,
                   output ecall_code, output ecall_arg, input ready);
   modport sink   (input valid, input next_pc, input reg_write_enable,
                   input reg_write_index, input reg_write_value, input status,
                   input ecall_code, input ecall_arg, output ready);
endinterface

interface rvx_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_pc;
   modport source (output valid, output start_pc, input ready);
   modport sink   (input valid, input start_pc, output ready);
endinterface

// ===== rtl/core/rvx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvx_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/rvx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_front
// Accepts instruction requests, classifies them and queues them (two entries).
// ----------------------------------------------------------------------------
module rvx_front (
   input  logic              clock,
   input  logic              reset,
   rvx_req_if.sink           req,
   input  logic              hold,
   output logic              q_valid,
   output rvx_pkg::item_type q_item,
   input  logic              q_pop
);

   function automatic rvx_pkg::class_type classify(input logic [31:0] ins);
      logic [6:0] opc;
      logic [2:0] f3;
      logic [6:0] f7;
      rvx_pkg::class_type cl;
      opc = ins[6:0];
      f3  = ins[14:12];
      f7  = ins[31:25];
      cl  = rvx_pkg::CL_ILLEGAL;
      case (opc)
         rvx_pkg::OPC_OP: begin
            if (f7 == rvx_pkg::F7_BASE) begin
               cl = rvx_pkg::CL_ALU_R;
            end else if (f7 == rvx_pkg::F7_ALT && f3 inside {3'd0, 3'd5}) begin
               cl = rvx_pkg::CL_ALU_R;
            end else if (f7 == rvx_pkg::F7_MULDIV && f3 inside {3'd0, 3'd1}) begin
               cl = rvx_pkg::CL_MUL;
            end else if (f7 == rvx_pkg::F7_MULDIV && f3 inside {3'd4, 3'd6}) begin
               cl = rvx_pkg::CL_DIV;
            end
         end
         rvx_pkg::OPC_OPIMM: begin
            if (f3 == 3'd1) begin
               if (f7 == rvx_pkg::F7_BASE) cl = rvx_pkg::CL_ALU_I;
            end else if (f3 == 3'd5) begin
               if (f7 == rvx_pkg::F7_BASE || f7 == rvx_pkg::F7_ALT) cl = rvx_pkg::CL_ALU_I;
            end else begin
               cl = rvx_pkg::CL_ALU_I;
            end
         end
         rvx_pkg::OPC_LOAD: begin
            if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) cl = rvx_pkg::CL_LOAD;
         end
         rvx_pkg::OPC_STORE: begin
            if (f3 inside {[3'd0:3'd2]}) cl = rvx_pkg::CL_STORE;
         end
         rvx_pkg::OPC_BRANCH: begin
            if (!(f3 inside {3'd2, 3'd3})) cl = rvx_pkg::CL_BRANCH;
         end
         rvx_pkg::OPC_JAL:   cl = rvx_pkg::CL_JAL;
         rvx_pkg::OPC_JALR: begin
            if (f3 == 3'd0) cl = rvx_pkg::CL_JALR;
         end
         rvx_pkg::OPC_AUIPC: cl = rvx_pkg::CL_AUIPC;
         rvx_pkg::OPC_LUI:   cl = rvx_pkg::CL_LUI;
         rvx_pkg::OPC_SYSTEM: begin
            if (ins == rvx_pkg::ECALL_WORD) cl = rvx_pkg::CL_ECALL;
         end
         default: cl = rvx_pkg::CL_ILLEGAL;
      endcase
      return cl;
   endfunction

   rvx_pkg::item_type ent_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   rvx_pkg::item_type new_item;

   // accept while there is room and the memory sweep is done
   assign req.ready = (count_ff != 2'd2) && !hold;
   assign push      = req.valid && req.ready;

   assign new_item.instruction = req.instruction;
   assign new_item.op_class    = classify(req.instruction);

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = ent_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/core/rvx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_back
// Executes queued instructions: register file, ALU, multiplier, serial
// divider, byte-serial data memory, PC and halt state, response register.
// ----------------------------------------------------------------------------
module rvx_back #(
   parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  rvx_pkg::item_type q_item,
   output logic              q_pop,
   output logic              clearing,
   rvx_rsp_if.source         rsp,
   rvx_csr_if.sink           csr
);

   localparam int unsigned AW = $clog2(MEM_BYTES);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_LOAD  = 4'd6;
   localparam logic [3:0] S_STORE = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   function automatic logic fits(input logic [31:0] addr, input logic [1:0] last);
      logic [32:0] top_byte;
      top_byte = {1'b0, addr} + {31'd0, last};
      return top_byte < 33'(MEM_BYTES);
   endfunction

   logic [3:0]          state_ff, state_in;
   rvx_pkg::item_type   item_ff, item_in;
   logic [31:0]         pc_ff, pc_in;
   logic                halted_ff, halted_in;
   logic [31:0]         rf_valid_ff, rf_valid_in;
   logic [AW-1:0]       clr_ff, clr_in;

   logic [31:0]         res_npc_ff, res_npc_in;
   logic                res_we_ff, res_we_in;
   logic [31:0]         res_val_ff, res_val_in;
   rvx_pkg::status_type res_st_ff, res_st_in;
   logic [31:0]         res_code_ff, res_code_in;
   logic [31:0]         res_arg_ff, res_arg_in;

   logic signed [63:0]  prod_ff, prod_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         quo_ff, quo_in;
   logic [31:0]         dvs_ff, dvs_in;
   logic                neg_q_ff, neg_q_in;
   logic                neg_r_ff, neg_r_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [2:0]          len_ff, len_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [31:0]         ld_ff, ld_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_npc_ff, rsp_npc_in;
   logic                rsp_we_ff, rsp_we_in;
   logic [4:0]          rsp_idx_ff, rsp_idx_in;
   logic [31:0]         rsp_val_ff, rsp_val_in;
   rvx_pkg::status_type rsp_st_ff, rsp_st_in;
   logic [31:0]         rsp_code_ff, rsp_code_in;
   logic [31:0]         rsp_arg_ff, rsp_arg_in;

   logic [31:0] ins;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [4:0]  rf_ra, rf_rb;
   logic [31:0] rdata_a, rdata_b, a_val, b_val;
   logic        rf_we;
   logic [31:0] imm_i, imm_s, imm_b, imm_j;
   logic [31:0] op2, alu_out;
   logic [4:0]  sh;
   logic        alt;
   logic        take;
   logic        mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata, mem_rdata;

   assign ins = item_ff.instruction;
   assign f3  = ins[14:12];
   assign rd  = ins[11:7];

   // register file: two copies, one per read port
   assign rf_ra = (item_ff.op_class == rvx_pkg::CL_ECALL) ? rvx_pkg::A0_INDEX : ins[19:15];
   assign rf_rb = (item_ff.op_class == rvx_pkg::CL_ECALL) ? rvx_pkg::A1_INDEX : ins[24:20];

   rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock(clock), .we(rf_we), .waddr(rd), .wdata(res_val_ff),
      .raddr(rf_ra), .rdata(rdata_a)
   );

   rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock(clock), .we(rf_we), .waddr(rd), .wdata(res_val_ff),
      .raddr(rf_rb), .rdata(rdata_b)
   );

   // never-written registers and x0 read as zero
   assign a_val = (rf_ra != 5'd0 && rf_valid_ff[rf_ra]) ? rdata_a : 32'd0;
   assign b_val = (rf_rb != 5'd0 && rf_valid_ff[rf_rb]) ? rdata_b : 32'd0;

   // data memory, one byte per cycle
   assign mem_raddr = base_ff + AW'(cnt_ff);

   rvx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   // immediates
   assign imm_i = {{20{ins[31]}}, ins[31:20]};
   assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
   assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
   assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

   // integer ALU
   always_comb begin
      op2 = (item_ff.op_class == rvx_pkg::CL_ALU_R) ? b_val : imm_i;
      sh  = op2[4:0];
      alt = ins[30] && ((f3 == 3'd5) || (item_ff.op_class == rvx_pkg::CL_ALU_R && f3 == 3'd0));
      case (f3)
         3'd0:    alu_out = alt ? (a_val - op2) : (a_val + op2);
         3'd1:    alu_out = a_val << sh;
         3'd2:    alu_out = {31'd0, $signed(a_val) < $signed(op2)};
         3'd3:    alu_out = {31'd0, a_val < op2};
         3'd4:    alu_out = a_val ^ op2;
         3'd5:    alu_out = alt ? 32'($signed(a_val) >>> sh) : (a_val >> sh);
         3'd6:    alu_out = a_val | op2;
         default: alu_out = a_val & op2;
      endcase
   end

   // branch condition
   always_comb begin
      case (f3)
         3'd0:    take = (a_val == b_val);
         3'd1:    take = (a_val != b_val);
         3'd4:    take = ($signed(a_val) < $signed(b_val));
         3'd5:    take = ($signed(a_val) >= $signed(b_val));
         3'd6:    take = (a_val < b_val);
         3'd7:    take = (a_val >= b_val);
         default: take = 1'b0;
      endcase
   end

   assign clearing = (state_ff == S_CLEAR);

   // sequencer
   always_comb begin
      logic [31:0] addr;
      logic [32:0] shifted, diff;
      logic [31:0] q_new, r_new, ld_word;
      logic [1:0]  last;
      logic        halting;

      state_in    = state_ff;
      item_in     = item_ff;
      pc_in       = pc_ff;
      halted_in   = halted_ff;
      rf_valid_in = rf_valid_ff;
      clr_in      = clr_ff;
      res_npc_in  = res_npc_ff;
      res_we_in   = res_we_ff;
      res_val_in  = res_val_ff;
      res_st_in   = res_st_ff;
      res_code_in = res_code_ff;
      res_arg_in  = res_arg_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      neg_q_in    = neg_q_ff;
      neg_r_in    = neg_r_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      base_in     = base_ff;
      ld_in       = ld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_npc_in  = rsp_npc_ff;
      rsp_we_in   = rsp_we_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_code_in = rsp_code_ff;
      rsp_arg_in  = rsp_arg_ff;
      q_pop       = 1'b0;
      rf_we       = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = mem_raddr;
      mem_wdata   = b_val[{cnt_ff[1:0], 3'b000} +: 8];

      addr    = 32'd0;
      last    = (f3[1:0] == 2'd0) ? 2'd0 : ((f3[1:0] == 2'd1) ? 2'd1 : 2'd3);
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      q_new   = 32'd0;
      r_new   = 32'd0;
      ld_word = ld_ff;
      halting = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // sweep the data memory to zero
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               item_in     = q_item;
               res_we_in   = 1'b0;
               res_val_in  = 32'd0;
               res_code_in = 32'd0;
               res_arg_in  = 32'd0;
               if (halted_ff) begin
                  res_st_in  = rvx_pkg::ST_HALTED;
                  res_npc_in = pc_ff;
                  state_in   = S_DONE;
               end else begin
                  res_st_in  = rvx_pkg::ST_OK;
                  res_npc_in = pc_ff + 32'd4;
                  state_in   = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (item_ff.op_class)
               rvx_pkg::CL_ALU_R, rvx_pkg::CL_ALU_I: begin
                  res_val_in = alu_out;
                  res_we_in  = 1'b1;
               end
               rvx_pkg::CL_MUL: begin
                  prod_in  = $signed(a_val) * $signed(b_val);
                  state_in = S_MUL;
               end
               rvx_pkg::CL_DIV: begin
                  if (b_val == 32'd0) begin
                     res_val_in = f3[1] ? a_val : 32'hFFFF_FFFF;
                     res_we_in  = 1'b1;
                  end else begin
                     rem_in   = 32'd0;
                     quo_in   = a_val[31] ? (32'd0 - a_val) : a_val;
                     dvs_in   = b_val[31] ? (32'd0 - b_val) : b_val;
                     neg_q_in = a_val[31] ^ b_val[31];
                     neg_r_in = a_val[31];
                     cnt_in   = 5'd0;
                     state_in = S_DIV;
                  end
               end
               rvx_pkg::CL_LOAD: begin
                  addr = a_val + imm_i;
                  if (!fits(addr, last)) begin
                     res_st_in = rvx_pkg::ST_LOAD_FAULT;
                  end else begin
                     base_in  = addr[AW-1:0];
                     len_in   = {1'b0, last} + 3'd1;
                     cnt_in   = 5'd0;
                     ld_in    = 32'd0;
                     state_in = S_LOAD;
                  end
               end
               rvx_pkg::CL_STORE: begin
                  addr = a_val + imm_s;
                  if (!fits(addr, last)) begin
                     res_st_in = rvx_pkg::ST_STORE_FAULT;
                  end else begin
                     base_in  = addr[AW-1:0];
                     len_in   = {1'b0, last} + 3'd1;
                     cnt_in   = 5'd0;
                     state_in = S_STORE;
                  end
               end
               rvx_pkg::CL_BRANCH: begin
                  if (take) res_npc_in = pc_ff + imm_b;
               end
               rvx_pkg::CL_JAL: begin
                  res_val_in = pc_ff + 32'd4;
                  res_we_in  = 1'b1;
                  res_npc_in = pc_ff + imm_j;
               end
               rvx_pkg::CL_JALR: begin
                  addr       = a_val + imm_i;
                  res_val_in = pc_ff + 32'd4;
                  res_we_in  = 1'b1;
                  res_npc_in = {addr[31:1], 1'b0};
               end
               rvx_pkg::CL_AUIPC: begin
                  res_val_in = pc_ff + {ins[31:12], 12'd0};
                  res_we_in  = 1'b1;
               end
               rvx_pkg::CL_LUI: begin
                  res_val_in = {ins[31:12], 12'd0};
                  res_we_in  = 1'b1;
               end
               rvx_pkg::CL_ECALL: begin
                  res_code_in = a_val;
                  res_arg_in  = b_val;
                  if (a_val == rvx_pkg::EC_PRINT_INT || a_val == rvx_pkg::EC_PRINT_STR ||
                      a_val == rvx_pkg::EC_PRINT_CHAR) begin
                     res_st_in = rvx_pkg::ST_ECALL;
                  end else if (a_val == rvx_pkg::EC_EXIT) begin
                     res_st_in = rvx_pkg::ST_EXIT;
                  end else begin
                     res_st_in = rvx_pkg::ST_ILLEGAL;
                  end
               end
               default: begin
                  res_st_in = rvx_pkg::ST_ILLEGAL;
               end
            endcase
         end
         S_MUL: begin
            res_val_in = f3[0] ? prod_ff[63:32] : prod_ff[31:0];
            res_we_in  = 1'b1;
            state_in   = S_DONE;
         end
         S_DIV: begin
            // one restoring step per cycle on magnitudes
            if (!diff[32]) begin
               r_new = diff[31:0];
               q_new = {quo_ff[30:0], 1'b1};
            end else begin
               r_new = shifted[31:0];
               q_new = {quo_ff[30:0], 1'b0};
            end
            rem_in = r_new;
            quo_in = q_new;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (f3[1]) begin
                  res_val_in = neg_r_ff ? (32'd0 - r_new) : r_new;
               end else begin
                  res_val_in = neg_q_ff ? (32'd0 - q_new) : q_new;
               end
               res_we_in = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_LOAD: begin
            // byte for the previous address arrives this cycle
            if (cnt_ff != 5'd0) begin
               ld_word[{cnt_ff[1:0] - 2'd1, 3'b000} +: 8] = mem_rdata;
            end
            ld_in  = ld_word;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == {2'd0, len_ff}) begin
               case (f3)
                  3'd0:    res_val_in = {{24{ld_word[7]}}, ld_word[7:0]};
                  3'd1:    res_val_in = {{16{ld_word[15]}}, ld_word[15:0]};
                  3'd4:    res_val_in = {24'd0, ld_word[7:0]};
                  3'd5:    res_val_in = {16'd0, ld_word[15:0]};
                  default: res_val_in = ld_word;
               endcase
               res_we_in = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_STORE: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == {2'd0, len_ff - 3'd1}) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // commit once the response register is free
            if (!rsp_valid_ff || rsp.ready) begin
               halting = (res_st_ff == rvx_pkg::ST_ILLEGAL) ||
                         (res_st_ff == rvx_pkg::ST_LOAD_FAULT) ||
                         (res_st_ff == rvx_pkg::ST_STORE_FAULT) ||
                         (res_st_ff == rvx_pkg::ST_EXIT);
               rf_we        = res_we_ff && !halting && (rd != 5'd0);
               rsp_valid_in = 1'b1;
               rsp_npc_in   = halting ? pc_ff : res_npc_ff;
               rsp_we_in    = rf_we;
               rsp_idx_in   = rf_we ? rd : 5'd0;
               rsp_val_in   = rf_we ? res_val_ff : 32'd0;
               rsp_st_in    = res_st_ff;
               rsp_code_in  = res_code_ff;
               rsp_arg_in   = res_arg_ff;
               pc_in        = halting ? pc_ff : res_npc_ff;
               if (halting) halted_in = 1'b1;
               if (rf_we) rf_valid_in[rd] = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // load the program counter from the start address register
      if (csr.valid) begin
         pc_in = csr.start_pc;
      end
   end

   assign csr.ready = 1'b1;

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.next_pc          = rsp_npc_ff;
   assign rsp.reg_write_enable = rsp_we_ff;
   assign rsp.reg_write_index  = rsp_idx_ff;
   assign rsp.reg_write_value  = rsp_val_ff;
   assign rsp.status           = rsp_st_ff;
   assign rsp.ecall_code       = rsp_code_ff;
   assign rsp.ecall_arg        = rsp_arg_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= 32'd0;
         halted_ff    <= 1'b0;
         rf_valid_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_npc_ff  <= res_npc_in;
      res_we_ff   <= res_we_in;
      res_val_ff  <= res_val_in;
      res_st_ff   <= res_st_in;
      res_code_ff <= res_code_in;
      res_arg_ff  <= res_arg_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      cnt_ff      <= cnt_in;
      len_ff      <= len_in;
      base_ff     <= base_in;
      ld_ff       <= ld_in;
      rsp_npc_ff  <= rsp_npc_in;
      rsp_we_ff   <= rsp_we_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_code_ff <= rsp_code_in;
      rsp_arg_ff  <= rsp_arg_in;
   end

endmodule

// ===== rtl/core/rv32im_instruction_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_instruction_execute
// RV32IM subset executor: front end queues classified instruction requests,
// back end executes them against register file, PC and byte data memory.
//
//   channel    dir   payload
//   req_chan   in    instruction
//   rsp_chan   out   next_pc, reg_write_*, status, ecall_code, ecall_arg
//   csr_chan   in    start_pc (loads the PC)
//
// After reset the data memory is swept to zero, one byte a cycle, with no
// request accepted meanwhile.
// Per request the back end steps through idle, read, exec and done (idle to
// done once halted); mul and mulh add a product step, div and rem a serial
// divider, one bit a cycle (skipped when the divisor is zero), loads and
// stores one byte a cycle (one data memory port).
// A two-entry queue and the response register let either side stall alone.
// ----------------------------------------------------------------------------
module rv32im_instruction_execute #(
   parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rvx_req_if.sink    req_chan,
   rvx_rsp_if.source  rsp_chan,
   rvx_csr_if.sink    csr_chan
);

   logic              q_valid;
   rvx_pkg::item_type q_item;
   logic              q_pop;
   logic              clearing;

   rvx_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .hold    (clearing),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   rvx_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp      (rsp_chan),
      .csr      (csr_chan)
   );

endmodule
